// ===== rtl/core/motor_feedback_frame_decoder_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the motor feedback frame decoder RTL.
// Every macro samples on clk and is disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_FRAME_DECODER_ASSERT_SVH
`define MOTOR_FEEDBACK_FRAME_DECODER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MFFD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define MFFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mffd_pkg.sv =====
// ---------------------------------------------------------------------------
// mffd_pkg
// Types, register map, reset values and saturation helper for the motor
// feedback frame decoder.
// ---------------------------------------------------------------------------
package mffd_pkg;

	// Default width of the signed multi-turn count
	localparam int ACCUM_WIDTH_DEF = 40;

	// Configuration port geometry
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ENCODER_SPAN      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_LIMIT     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TEMPERATURE_LIMIT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HAS_TEMPERATURE   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_POSITION_SCALE    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_SCALE    = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_EFFORT_SCALE      = 3'd7;

	// Register reset values
	localparam logic [15:0] ENCODER_SPAN_RST      = 16'd8192;
	localparam logic [14:0] SPEED_LIMIT_RST       = 15'd10000;
	localparam logic [14:0] CURRENT_LIMIT_RST     = 15'd16384;
	localparam logic [7:0]  TEMPERATURE_LIMIT_RST = 8'd125;
	localparam logic        HAS_TEMPERATURE_RST   = 1'b1;
	localparam logic [31:0] POSITION_SCALE_RST    = 32'd171545;
	localparam logic [31:0] VELOCITY_SCALE_RST    = 32'd23421315;
	localparam logic [31:0] EFFORT_SCALE_RST      = 32'd1572864;

	typedef enum logic [1:0] {
		STATUS_UPDATED  = 2'd0,
		STATUS_PRIMED   = 2'd1,
		STATUS_REJECTED = 2'd2
	} status_t;

	typedef struct packed {
		logic [15:0] encoder_span;
		logic [14:0] speed_limit;
		logic [14:0] current_limit;
		logic [7:0]  temperature_limit;
		logic        has_temperature;
		logic [31:0] position_scale;
		logic [31:0] velocity_scale;
		logic [31:0] effort_scale;
	} cfg_t;

	typedef struct packed {
		logic        [15:0] enc;
		logic signed [15:0] rpm;
		logic signed [15:0] cur;
		logic        [7:0]  temp;
	} readings_t;

	typedef struct packed {
		status_t            status;
		logic signed [47:0] position_rad;
		logic signed [31:0] angle_rad;
		logic        [15:0] encoder_count;
		logic signed [31:0] velocity_rad_s;
		logic signed [15:0] speed_rpm;
		logic signed [31:0] effort_nm;
		logic signed [15:0] current_raw;
		logic        [7:0]  temperature_c;
	} result_t;

	// Drop 16 fraction bits of a 17x33 product (floor) and saturate to Q16.16
	function automatic logic signed [31:0] sat_q16(input logic signed [49:0] p);
		logic signed [33:0] q;
		logic               ovf;
		q   = p[49:16];
		ovf = !((&q[33:31]) || !(|q[33:31]));
		if (ovf) begin
			sat_q16 = q[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sat_q16 = q[31:0];
		end
	endfunction

endpackage

// ===== rtl/core/mffd_frame_if.sv =====
// ---------------------------------------------------------------------------
// mffd_frame_if
// Valid/ready channel carrying one 8-byte feedback frame.
// ---------------------------------------------------------------------------
interface mffd_frame_if;
	logic        valid;
	logic        ready;
	logic [63:0] frame_payload;

	modport source (output valid, output frame_payload, input ready);
	modport sink (input valid, input frame_payload, output ready);
endinterface

// ===== rtl/core/mffd_result_if.sv =====
// ---------------------------------------------------------------------------
// mffd_result_if
// Valid/ready channel carrying one decoded feedback result.
// ---------------------------------------------------------------------------
interface mffd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [47:0] position_rad;
	logic [31:0] angle_rad;
	logic [15:0] encoder_count;
	logic [31:0] velocity_rad_s;
	logic [15:0] speed_rpm;
	logic [31:0] effort_nm;
	logic [15:0] current_raw;
	logic [7:0]  temperature_c;

	modport source (
		output valid, output status, output position_rad, output angle_rad,
		output encoder_count, output velocity_rad_s, output speed_rpm,
		output effort_nm, output current_raw, output temperature_c,
		input ready
	);
	modport sink (
		input valid, input status, input position_rad, input angle_rad,
		input encoder_count, input velocity_rad_s, input speed_rpm,
		input effort_nm, input current_raw, input temperature_c,
		output ready
	);
endinterface

// ===== rtl/core/mffd_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// mffd_cfg_regs
// Configuration register file: write-only, one register per index.
// ---------------------------------------------------------------------------
module mffd_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mffd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mffd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output mffd_pkg::cfg_t                   cfg
);
	import mffd_pkg::*;

	cfg_t cfg_q;

	// Load the addressed register, truncated to its width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.encoder_span      <= ENCODER_SPAN_RST;
			cfg_q.speed_limit       <= SPEED_LIMIT_RST;
			cfg_q.current_limit     <= CURRENT_LIMIT_RST;
			cfg_q.temperature_limit <= TEMPERATURE_LIMIT_RST;
			cfg_q.has_temperature   <= HAS_TEMPERATURE_RST;
			cfg_q.position_scale    <= POSITION_SCALE_RST;
			cfg_q.velocity_scale    <= VELOCITY_SCALE_RST;
			cfg_q.effort_scale      <= EFFORT_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENCODER_SPAN:      cfg_q.encoder_span      <= cfg_wdata[15:0];
				REG_SPEED_LIMIT:       cfg_q.speed_limit       <= cfg_wdata[14:0];
				REG_CURRENT_LIMIT:     cfg_q.current_limit     <= cfg_wdata[14:0];
				REG_TEMPERATURE_LIMIT: cfg_q.temperature_limit <= cfg_wdata[7:0];
				REG_HAS_TEMPERATURE:   cfg_q.has_temperature   <= cfg_wdata[0];
				REG_POSITION_SCALE:    cfg_q.position_scale    <= cfg_wdata[31:0];
				REG_VELOCITY_SCALE:    cfg_q.velocity_scale    <= cfg_wdata[31:0];
				REG_EFFORT_SCALE:      cfg_q.effort_scale      <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/mffd_scale.sv =====
// ---------------------------------------------------------------------------
// mffd_scale
// Four-stage stallable pipeline turning a state snapshot into the scaled
// fixed-point result: capture, multiply, combine, saturate.
// ---------------------------------------------------------------------------
module mffd_scale #(
	parameter int ACCUM_WIDTH = mffd_pkg::ACCUM_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mffd_pkg::cfg_t               cfg,
	input  logic                         snap_valid,
	output logic                         snap_ready,
	input  mffd_pkg::status_t            snap_status,
	input  logic signed [ACCUM_WIDTH-1:0] snap_acc,
	input  mffd_pkg::readings_t          snap_rd,
	output logic                         res_valid,
	input  logic                         res_ready,
	output mffd_pkg::result_t            res
);
	import mffd_pkg::*;

	localparam int LO_W  = ACCUM_WIDTH / 2;
	localparam int HI_W  = ACCUM_WIDTH - LO_W;
	localparam int SUM_W = ACCUM_WIDTH + 33;
	localparam int Q_W   = SUM_W - 16;

	// Per-stage valid and advance
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4      = !v_s4 || res_ready;
	assign en_s3      = !v_s3 || en_s4;
	assign en_s2      = !v_s2 || en_s3;
	assign en_s1      = !v_s1 || en_s2;
	assign snap_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= snap_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: capture snapshot
	status_t                  status_s1;
	logic signed [ACCUM_WIDTH-1:0] acc_s1;
	readings_t                rd_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			status_s1 <= snap_status;
			acc_s1    <= snap_acc;
			rd_s1     <= snap_rd;
		end
	end

	// Stage 2: partial products of the turn count and the reading products
	status_t                   status_s2;
	readings_t                 rd_s2;
	logic        [LO_W+31:0]   pp_lo_s2;
	logic signed [HI_W+32:0]   pp_hi_s2;
	logic signed [49:0]        p_ang_s2;
	logic signed [49:0]        p_vel_s2;
	logic signed [49:0]        p_eff_s2;
	logic        [LO_W-1:0]    acc_lo;
	logic signed [HI_W-1:0]    acc_hi;

	assign acc_lo = acc_s1[LO_W-1:0];
	assign acc_hi = acc_s1[ACCUM_WIDTH-1:LO_W];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			status_s2 <= status_s1;
			rd_s2     <= rd_s1;
			pp_lo_s2  <= acc_lo * cfg.position_scale;
			pp_hi_s2  <= acc_hi * $signed({1'b0, cfg.position_scale});
			p_ang_s2  <= $signed({1'b0, rd_s1.enc}) * $signed({1'b0, cfg.position_scale});
			p_vel_s2  <= $signed({rd_s1.rpm[15], rd_s1.rpm})
				* $signed({1'b0, cfg.velocity_scale});
			p_eff_s2  <= $signed({rd_s1.cur[15], rd_s1.cur})
				* $signed({1'b0, cfg.effort_scale});
		end
	end

	// Stage 3: combine partial products, saturate the Q16.16 outputs
	status_t                  status_s3;
	readings_t                rd_s3;
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [31:0]       ang_s3;
	logic signed [31:0]       vel_s3;
	logic signed [31:0]       eff_s3;
	logic signed [SUM_W-1:0]  sum_nxt;

	assign sum_nxt = $signed({pp_hi_s2, {LO_W{1'b0}}})
		+ $signed({{(HI_W+1){1'b0}}, pp_lo_s2});

	always_ff @(posedge clk) begin
		if (en_s3) begin
			status_s3 <= status_s2;
			rd_s3     <= rd_s2;
			sum_s3    <= sum_nxt;
			ang_s3    <= sat_q16(p_ang_s2);
			vel_s3    <= sat_q16(p_vel_s2);
			eff_s3    <= sat_q16(p_eff_s2);
		end
	end

	// Stage 4: floor and saturate the position to Q32.16
	logic signed [Q_W-1:0] pos_q;
	logic signed [47:0]    pos_sat;

	assign pos_q = sum_s3[SUM_W-1:16];

	generate
		if (Q_W >= 48) begin : g_pos_clip
			logic pos_ovf;
			assign pos_ovf = !((&pos_q[Q_W-1:47]) || !(|pos_q[Q_W-1:47]));
			assign pos_sat = pos_ovf
				? (pos_q[Q_W-1] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}})
				: pos_q[47:0];
		end else begin : g_pos_ext
			assign pos_sat = {{(48-Q_W){pos_q[Q_W-1]}}, pos_q};
		end
	endgenerate

	result_t res_q;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			res_q.status         <= status_s3;
			res_q.position_rad   <= pos_sat;
			res_q.angle_rad      <= ang_s3;
			res_q.encoder_count  <= rd_s3.enc;
			res_q.velocity_rad_s <= vel_s3;
			res_q.speed_rpm      <= rd_s3.rpm;
			res_q.effort_nm      <= eff_s3;
			res_q.current_raw    <= rd_s3.cur;
			res_q.temperature_c  <= cfg.has_temperature ? rd_s3.temp : 8'd0;
		end
	end

	assign res_valid = v_s4;
	assign res       = res_q;

endmodule

// ===== rtl/core/motor_feedback_frame_decoder.sv =====
// ---------------------------------------------------------------------------
// motor_feedback_frame_decoder
// Decodes 8-byte motor feedback frames into raw and fixed-point readings.
// ---------------------------------------------------------------------------
// One frame is accepted every clock cycle while the result side keeps up,
// and each frame yields one result. Range checks, encoder unwrap and the
// saturating turn-count update are done in the accept cycle, so every frame
// sees the state left by the one before. The scaled outputs then pass
// through a pipeline of capture, multiply, combine and saturate; the turn
// count is multiplied as two half-width partial products that are added in
// the following stage. A stall on the result channel backs up through the
// pipeline to frame.ready, and bubbles are squeezed out. Configuration must
// be written only while no frame is in flight; the block itself does not
// enforce this.
`include "motor_feedback_frame_decoder_assert.svh"

module motor_feedback_frame_decoder #(
	parameter int ACCUM_WIDTH = mffd_pkg::ACCUM_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	mffd_frame_if.sink                       frame,
	mffd_result_if.source                    result,
	input  logic                             cfg_we,
	input  logic [mffd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mffd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import mffd_pkg::*;

	cfg_t cfg;

	mffd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Unpack the frame
	logic        [15:0] enc;
	logic signed [15:0] rpm;
	logic signed [15:0] cur;
	logic        [7:0]  temp;

	assign enc  = frame.frame_payload[63:48];
	assign rpm  = frame.frame_payload[47:32];
	assign cur  = frame.frame_payload[31:16];
	assign temp = frame.frame_payload[15:8];

	// Range checks against the configured limits
	logic signed [16:0] rpm_x, cur_x, slim_x, clim_x;
	logic               rejected;

	assign rpm_x  = {rpm[15], rpm};
	assign cur_x  = {cur[15], cur};
	assign slim_x = {2'b00, cfg.speed_limit};
	assign clim_x = {2'b00, cfg.current_limit};

	assign rejected = (enc > cfg.encoder_span)
		|| (rpm_x > slim_x) || (rpm_x < -slim_x)
		|| (cur_x > clim_x) || (cur_x < -clim_x)
		|| (temp > cfg.temperature_limit);

	// Turn state
	logic                          primed_q;
	logic [15:0]                   prev_enc_q;
	logic signed [ACCUM_WIDTH-1:0] acc_q;
	readings_t                     held_q;

	// Unwrap the encoder step by half the span
	logic signed [18:0] half_x, span_x, d_raw, d_lo, d_fix;

	assign half_x = {4'b0000, cfg.encoder_span[15:1]};
	assign span_x = {3'b000, cfg.encoder_span};
	assign d_raw  = $signed({3'b000, enc}) - $signed({3'b000, prev_enc_q});
	assign d_lo   = (d_raw < -half_x) ? d_raw + span_x : d_raw;
	assign d_fix  = (d_lo > half_x) ? d_lo - span_x : d_lo;

	// Saturating add into the turn count
	logic signed [ACCUM_WIDTH:0]   acc_sum;
	logic signed [ACCUM_WIDTH-1:0] acc_add;

	assign acc_sum = {acc_q[ACCUM_WIDTH-1], acc_q}
		+ {{(ACCUM_WIDTH-18){d_fix[18]}}, d_fix};
	assign acc_add = (acc_sum[ACCUM_WIDTH] != acc_sum[ACCUM_WIDTH-1])
		? {acc_sum[ACCUM_WIDTH], {(ACCUM_WIDTH-1){!acc_sum[ACCUM_WIDTH]}}}
		: acc_sum[ACCUM_WIDTH-1:0];

	// Next state and status for the frame on the input
	logic                          snap_ready;
	logic                          frame_acc;
	status_t                       status_nxt;
	logic                          primed_nxt;
	logic [15:0]                   prev_enc_nxt;
	logic signed [ACCUM_WIDTH-1:0] acc_nxt;
	readings_t                     held_nxt;

	assign frame.ready = snap_ready;
	assign frame_acc   = frame.valid && snap_ready;

	always_comb begin
		status_nxt   = STATUS_REJECTED;
		primed_nxt   = primed_q;
		prev_enc_nxt = prev_enc_q;
		acc_nxt      = acc_q;
		held_nxt     = held_q;
		if (!rejected) begin
			prev_enc_nxt = enc;
			primed_nxt   = 1'b1;
			if (!primed_q) begin
				status_nxt = STATUS_PRIMED;
			end else begin
				status_nxt    = STATUS_UPDATED;
				acc_nxt       = acc_add;
				held_nxt.enc  = enc;
				held_nxt.rpm  = rpm;
				held_nxt.cur  = cur;
				held_nxt.temp = temp;
			end
		end
	end

	// Commit turn state on each accepted frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q   <= 1'b0;
			prev_enc_q <= '0;
			acc_q      <= '0;
			held_q     <= '0;
		end else if (frame_acc) begin
			primed_q   <= primed_nxt;
			prev_enc_q <= prev_enc_nxt;
			acc_q      <= acc_nxt;
			held_q     <= held_nxt;
		end
	end

	// Scale pipeline and result register
	logic    res_valid;
	result_t res;

	mffd_scale #(
		.ACCUM_WIDTH (ACCUM_WIDTH)
	) u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.snap_valid  (frame.valid),
		.snap_ready  (snap_ready),
		.snap_status (status_nxt),
		.snap_acc    (acc_nxt),
		.snap_rd     (held_nxt),
		.res_valid   (res_valid),
		.res_ready   (result.ready),
		.res         (res)
	);

	assign result.valid          = res_valid;
	assign result.status         = res.status;
	assign result.position_rad   = res.position_rad;
	assign result.angle_rad      = res.angle_rad;
	assign result.encoder_count  = res.encoder_count;
	assign result.velocity_rad_s = res.velocity_rad_s;
	assign result.speed_rpm      = res.speed_rpm;
	assign result.effort_nm      = res.effort_nm;
	assign result.current_raw    = res.current_raw;
	assign result.temperature_c  = res.temperature_c;

	// Turn state checks
	`MFFD_ASSERT_NEXT(a_reject_keeps_state, frame_acc && rejected,
		$stable(acc_q) && $stable(prev_enc_q) && $stable(held_q),
		"rejected frame changed turn state")
	`MFFD_ASSERT_NEXT(a_idle_keeps_state, !frame_acc,
		$stable(acc_q) && $stable(prev_enc_q) && $stable(primed_q),
		"turn state moved without an accepted frame")
	`MFFD_ASSERT_NEXT(a_primed_sticky, primed_q, primed_q, "primed flag cleared")
	`MFFD_ASSERT_NEXT(a_prime_loads_encoder, frame_acc && !rejected && !primed_q,
		primed_q && (prev_enc_q == $past(enc)) && $stable(acc_q),
		"priming frame did not load the encoder only")
	`MFFD_ASSERT_SAME(a_updated_only_primed, frame_acc && (status_nxt == STATUS_UPDATED),
		primed_q && !rejected, "update reported while not primed")

endmodule

// ===== dv/mffd_tb_pkg.sv =====
// ---------------------------------------------------------------------------
// Feedback decoder scoreboard
// Tracks the decoder's configuration, turn count and held readings, works out
// the readout that each accepted frame should produce and checks the
// readouts that leave the block in order.
// ---------------------------------------------------------------------------
package mffd_tb_pkg;

	import mffd_pkg::*;

	class feedback_scoreboard;

		cfg_t        settings;
		bit          primed;
		logic [15:0] last_encoder;
		longint      turn_count;
		readings_t   held;
		result_t     pending_readouts[$];
		int          mismatches;

		function new();
			settings.encoder_span      = ENCODER_SPAN_RST;
			settings.speed_limit       = SPEED_LIMIT_RST;
			settings.current_limit     = CURRENT_LIMIT_RST;
			settings.temperature_limit = TEMPERATURE_LIMIT_RST;
			settings.has_temperature   = HAS_TEMPERATURE_RST;
			settings.position_scale    = POSITION_SCALE_RST;
			settings.velocity_scale    = VELOCITY_SCALE_RST;
			settings.effort_scale      = EFFORT_SCALE_RST;
			primed       = 1'b0;
			last_encoder = '0;
			turn_count   = 0;
			held         = '0;
			mismatches   = 0;
		endfunction

		// Mirror one register write, keeping only the register's own bits
		function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
			case (index)
				REG_ENCODER_SPAN:      settings.encoder_span      = value[15:0];
				REG_SPEED_LIMIT:       settings.speed_limit       = value[14:0];
				REG_CURRENT_LIMIT:     settings.current_limit     = value[14:0];
				REG_TEMPERATURE_LIMIT: settings.temperature_limit = value[7:0];
				REG_HAS_TEMPERATURE:   settings.has_temperature   = value[0];
				REG_POSITION_SCALE:    settings.position_scale    = value;
				REG_VELOCITY_SCALE:    settings.velocity_scale    = value;
				REG_EFFORT_SCALE:      settings.effort_scale      = value;
				default: ;
			endcase
		endfunction

		// Exact product with a Q0.32 scale, floor by 2^16, clamp to a signed width
		function longint scale_fixed(longint value, logic [31:0] scale, int width);
			logic signed [79:0] wide_value;
			logic signed [79:0] wide_scale;
			logic signed [79:0] prod;
			longint             top;
			longint             bottom;
			wide_value = value;
			wide_scale = {48'd0, scale};
			prod       = (wide_value * wide_scale) >>> 16;
			top        = (longint'(1) <<< (width - 1)) - 1;
			bottom     = -top - 1;
			if (prod > top) return top;
			if (prod < bottom) return bottom;
			return longint'(prod);
		endfunction

		// Decode one accepted frame, advance the state and queue its readout
		function void note_frame(logic [63:0] payload);
			logic [15:0]        enc;
			logic signed [15:0] rpm;
			logic signed [15:0] cur;
			logic [7:0]         temp;
			int                 half;
			int                 step;
			longint             acc_max;
			longint             acc_min;
			result_t            readout;
			enc  = payload[63:48];
			rpm  = payload[47:32];
			cur  = payload[31:16];
			temp = payload[15:8];
			if (enc > settings.encoder_span ||
			    int'(rpm) > int'(settings.speed_limit) ||
			    int'(rpm) < -int'(settings.speed_limit) ||
			    int'(cur) > int'(settings.current_limit) ||
			    int'(cur) < -int'(settings.current_limit) ||
			    temp > settings.temperature_limit) begin
				readout.status = STATUS_REJECTED;
			end else if (!primed) begin
				// first good frame only seeds the encoder history
				last_encoder   = enc;
				primed         = 1'b1;
				readout.status = STATUS_PRIMED;
			end else begin
				// unwrap the encoder step across the revolution boundary
				half    = int'(settings.encoder_span) / 2;
				step    = int'(enc) - int'(last_encoder);
				acc_max = (longint'(1) <<< (ACCUM_WIDTH_DEF - 1)) - 1;
				acc_min = -acc_max - 1;
				if (step < -half) step += int'(settings.encoder_span);
				if (step > half) step -= int'(settings.encoder_span);
				last_encoder = enc;
				if (step > 0 && turn_count > acc_max - step) turn_count = acc_max;
				else if (step < 0 && turn_count < acc_min - step) turn_count = acc_min;
				else turn_count += step;
				held.enc       = enc;
				held.rpm       = rpm;
				held.cur       = cur;
				held.temp      = temp;
				readout.status = STATUS_UPDATED;
			end
			readout.position_rad   = 48'(scale_fixed(turn_count, settings.position_scale, 48));
			readout.angle_rad      = 32'(scale_fixed(longint'(held.enc),
				settings.position_scale, 32));
			readout.encoder_count  = held.enc;
			readout.velocity_rad_s = 32'(scale_fixed(longint'(held.rpm),
				settings.velocity_scale, 32));
			readout.speed_rpm      = held.rpm;
			readout.effort_nm      = 32'(scale_fixed(longint'(held.cur),
				settings.effort_scale, 32));
			readout.current_raw    = held.cur;
			readout.temperature_c  = settings.has_temperature ? held.temp : 8'd0;
			pending_readouts.push_back(readout);
		endfunction

		task report_mismatch(string what);
			$display("ERROR %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task compare_field(string name, logic [63:0] seen, logic [63:0] want);
			if (seen !== want) begin
				report_mismatch($sformatf("%s got %h want %h", name, seen, want));
			end
		endtask

		// Check one readout against the oldest one still owed
		task check_readout(result_t seen);
			result_t want;
			if (pending_readouts.size() == 0) begin
				report_mismatch("readout with no frame outstanding");
				return;
			end
			want = pending_readouts.pop_front();
			compare_field("status", seen.status, want.status);
			compare_field("position_rad", seen.position_rad, want.position_rad);
			compare_field("angle_rad", seen.angle_rad, want.angle_rad);
			compare_field("encoder_count", seen.encoder_count, want.encoder_count);
			compare_field("velocity_rad_s", seen.velocity_rad_s, want.velocity_rad_s);
			compare_field("speed_rpm", seen.speed_rpm, want.speed_rpm);
			compare_field("effort_nm", seen.effort_nm, want.effort_nm);
			compare_field("current_raw", seen.current_raw, want.current_raw);
			compare_field("temperature_c", seen.temperature_c, want.temperature_c);
		endtask

	endclass

endpackage

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Drives feedback frames into the decoder under several register settings,
// with random send gaps and random result back-pressure, and checks every
// readout against the scoreboard's own decode of the same frames.
// ---------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import mffd_pkg::*;
	import mffd_tb_pkg::*;

	localparam int STALL_LIMIT     = 2000;
	localparam int SETTLE_CYCLES   = 6;
	localparam int PHASE_COUNT     = 9;
	localparam int FRAMES_PER_PHASE = 215;
	localparam int DRAIN_INTERVAL  = 100;

	// Kinds of register setting
	localparam int SET_RESET  = 0;
	localparam int SET_HIGH   = 1;
	localparam int SET_LOW    = 2;
	localparam int SET_SPAN1  = 3;
	localparam int SET_SPAN0  = 4;
	localparam int SET_RANDOM = 5;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	int                     send_idle_pct;
	int                     recv_idle_pct;
	int                     idle_cycles = 0;

	feedback_scoreboard board = new();

	mffd_frame_if  frame_bus ();
	mffd_result_if result_bus ();

	motor_feedback_frame_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame_bus),
		.result    (result_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the result side at random
	always @(negedge clk) begin
		result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Collect transactions on both channels and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (frame_bus.valid && frame_bus.ready) begin
				board.note_frame(frame_bus.frame_payload);
			end
			if (result_bus.valid && result_bus.ready) begin
				board.check_readout({result_bus.status, result_bus.position_rad,
					result_bus.angle_rad, result_bus.encoder_count, result_bus.velocity_rad_s,
					result_bus.speed_rpm, result_bus.effort_nm, result_bus.current_raw,
					result_bus.temperature_c});
			end
			if ((frame_bus.valid && frame_bus.ready) ||
			    (result_bus.valid && result_bus.ready) || cfg_we) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	function automatic logic [63:0] pack_frame(logic [15:0] enc, logic [15:0] rpm,
	                                           logic [15:0] cur, logic [7:0] temp);
		return {enc, rpm, cur, temp, 8'($urandom)};
	endfunction

	// Mostly in-range frames, some pushed just past one limit, some pure noise
	function automatic logic [63:0] make_frame(cfg_t s);
		int          pick;
		int          span;
		int          slim;
		int          clim;
		logic [15:0] enc;
		logic [15:0] rpm;
		logic [15:0] cur;
		logic [63:0] frame;
		pick = $urandom_range(99);
		if (pick < 10) return {$urandom, $urandom};
		span = s.encoder_span;
		slim = s.speed_limit;
		clim = s.current_limit;
		case ($urandom_range(9))
			0: enc = 16'd0;
			1: enc = s.encoder_span;
			default: enc = 16'($urandom_range(0, span));
		endcase
		rpm = 16'($urandom_range(0, 2 * slim) - slim);
		cur = 16'($urandom_range(0, 2 * clim) - clim);
		if ($urandom_range(9) == 0) rpm = $urandom_range(1) ? 16'(slim) : 16'(-slim);
		if ($urandom_range(9) == 0) cur = $urandom_range(1) ? 16'(clim) : 16'(-clim);
		frame = pack_frame(enc, rpm, cur, 8'($urandom_range(0, s.temperature_limit)));
		if (pick < 22) begin
			case ($urandom_range(3))
				0: frame[63:48] = 16'(span + 1 + $urandom_range(3));
				1: frame[47:32] = $urandom_range(1) ? 16'(slim + 1) : 16'(-slim - 1);
				2: frame[31:16] = $urandom_range(1) ? 16'(clim + 1) : 16'(-clim - 1);
				default: frame[15:8] = 8'(s.temperature_limit + 1);
			endcase
		end
		return frame;
	endfunction

	function automatic cfg_t make_settings(int kind);
		cfg_t s;
		s.encoder_span      = 16'($urandom_range(2, 32768));
		s.speed_limit       = 15'($urandom);
		s.current_limit     = 15'($urandom);
		s.temperature_limit = 8'($urandom);
		s.has_temperature   = 1'($urandom);
		s.position_scale    = $urandom >> $urandom_range(0, 24);
		s.velocity_scale    = $urandom >> $urandom_range(0, 24);
		s.effort_scale      = $urandom >> $urandom_range(0, 24);
		case (kind)
			SET_RESET: begin
				s = {ENCODER_SPAN_RST, SPEED_LIMIT_RST, CURRENT_LIMIT_RST,
					TEMPERATURE_LIMIT_RST, HAS_TEMPERATURE_RST, POSITION_SCALE_RST,
					VELOCITY_SCALE_RST, EFFORT_SCALE_RST};
			end
			SET_HIGH: begin
				s = '1;
			end
			SET_LOW: begin
				s = '0;
				s.encoder_span = 16'd2;
			end
			SET_SPAN1: s.encoder_span = 16'd1;
			SET_SPAN0: s.encoder_span = 16'd0;
			default: ;
		endcase
		return s;
	endfunction

	// Present one frame and hold it until the decoder takes it
	task automatic send_frame(logic [63:0] payload);
		while ($urandom_range(99) < send_idle_pct) begin
			frame_bus.valid <= 1'b0;
			@(negedge clk);
		end
		frame_bus.valid         <= 1'b1;
		frame_bus.frame_payload <= payload;
		do @(posedge clk); while (!frame_bus.ready);
		@(negedge clk);
	endtask

	// Stop sending and wait out every readout still owed
	task automatic drain_results();
		frame_bus.valid <= 1'b0;
		while (board.pending_readouts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		board.set_register(index, value);
		@(negedge clk);
	endtask

	task automatic apply_settings(cfg_t s);
		put_register(REG_ENCODER_SPAN, 32'(s.encoder_span));
		put_register(REG_SPEED_LIMIT, 32'(s.speed_limit));
		put_register(REG_CURRENT_LIMIT, 32'(s.current_limit));
		put_register(REG_TEMPERATURE_LIMIT, 32'(s.temperature_limit));
		put_register(REG_HAS_TEMPERATURE, 32'(s.has_temperature));
		put_register(REG_POSITION_SCALE, s.position_scale);
		put_register(REG_VELOCITY_SCALE, s.velocity_scale);
		put_register(REG_EFFORT_SCALE, s.effort_scale);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [63:0] directed[$];
		int          phase_kinds[PHASE_COUNT];
		arst_n                  = 1'b0;
		frame_bus.valid         = 1'b0;
		frame_bus.frame_payload = '0;
		result_bus.ready        = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = '0;
		cfg_wdata               = '0;
		send_idle_pct           = 18;
		recv_idle_pct           = 45;
		phase_kinds = '{SET_RANDOM, SET_HIGH, SET_LOW, SET_RANDOM, SET_SPAN1,
			SET_RESET, SET_SPAN0, SET_RANDOM, SET_HIGH};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames under the reset settings: priming, unwrap edges, limits
		directed.push_back(pack_frame(16'd8193, 16'd0, 16'd0, 8'd0));
		directed.push_back(pack_frame(16'd8192, 16'd10000, 16'(-16384), 8'd125));
		directed.push_back(pack_frame(16'd0, 16'(-10000), 16'd16384, 8'd0));
		directed.push_back(pack_frame(16'd4096, 16'd1, 16'd1, 8'd1));
		directed.push_back(pack_frame(16'd0, 16'd2, 16'd2, 8'd2));
		directed.push_back(pack_frame(16'd4097, 16'd3, 16'd3, 8'd3));
		directed.push_back(pack_frame(16'd0, 16'd4, 16'd4, 8'd4));
		directed.push_back(pack_frame(16'd100, 16'd10001, 16'd0, 8'd0));
		directed.push_back(pack_frame(16'd100, 16'(-10001), 16'd0, 8'd0));
		directed.push_back(pack_frame(16'd100, 16'd0, 16'd16385, 8'd0));
		directed.push_back(pack_frame(16'd100, 16'd0, 16'(-16385), 8'd0));
		directed.push_back(pack_frame(16'd100, 16'd0, 16'd0, 8'd126));
		directed.push_back(pack_frame(16'hFFFF, 16'd0, 16'd0, 8'd0));
		directed.push_back(pack_frame(16'd100, 16'h8000, 16'd0, 8'd0));
		directed.push_back(pack_frame(16'd100, 16'd0, 16'h8000, 8'd0));
		directed.push_back(pack_frame(16'd100, 16'd0, 16'd0, 8'hFF));
		directed.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		directed.push_back(64'h0);
		directed.push_back(pack_frame(16'd8191, 16'd1, 16'hFFFF, 8'd1));
		directed.push_back(pack_frame(16'd1, 16'd9999, 16'd16383, 8'd124));
		foreach (directed[i]) send_frame(directed[i]);
		drain_results();

		// Random frames, one register setting per phase
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			send_idle_pct = (phase < 3) ? 18 : (phase < 6) ? 45 : 0;
			recv_idle_pct = (phase < 3) ? 45 : (phase < 6) ? 18 : 0;
			apply_settings(make_settings(phase_kinds[phase]));
			for (int item = 0; item < FRAMES_PER_PHASE; item++) begin
				send_frame(make_frame(board.settings));
				if (item % DRAIN_INTERVAL == DRAIN_INTERVAL - 1) drain_results();
			end
			drain_results();
		end

		if (board.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mffd_pkg.sv
rtl/core/mffd_frame_if.sv
rtl/core/mffd_result_if.sv
rtl/core/mffd_cfg_regs.sv
rtl/core/mffd_scale.sv
rtl/core/motor_feedback_frame_decoder.sv
dv/mffd_tb_pkg.sv
dv/tb_top.sv
